// ===== rtl/core/btpc_pkg.sv =====
`default_nettype none
package btpc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegCoefA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefC = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefD = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOss   = 3'd4;

  localparam logic [31:0] B6Offset  = 32'd4000;
  localparam logic [31:0] B4Offset  = 32'd32768;
  localparam logic [31:0] B7Scale   = 32'd50000;
  localparam logic [31:0] PCoefA    = 32'd3038;
  localparam logic [31:0] PCoefB    = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PCoefC    = 32'd3791;

  localparam logic ReqTemp = 1'b0;
  localparam logic ReqPres = 1'b1;

  // 32x32 multiply, low word
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/barometer_temp_pressure_compensation.sv =====
// Barometric sensor compensation, integer form.
// Input channel (s_axis_*): one beat per raw conversion. tuser = request type
// (0 temperature, 1 pressure); tdata = 24-bit raw reading.
// Output channel (m_axis_*): one beat per input. tuser = {error, kind};
// tdata = signed 32-bit value (0.1 degC or Pa), 0 when error is set.
// Config channel (cfg_*): register index and data; cfg_ready is high only in
// idle, so registers never change under an item in flight.
// One shared 32x32 multiplier runs under a step sequencer; divisions use a
// shared radix-2 restoring divider, one quotient bit per cycle.
// A zero divisor skips the division.
// One item in flight: s_axis_tready is high only in idle, so the block takes
// no new beat until the last result has been taken. The result sits in an
// output register until taken; a stalled receiver holds the block in that
// state.
// Reset clears the stored B5 value and coefficients, sets oversampling to 1.
`default_nettype none
module barometer_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // raw_reading[23:0]
  input  wire logic                s_axis_tuser,  // req_type
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // value[31:0]
  output logic [1:0]               m_axis_tuser,  // kind[0], error[1]
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StPost = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [47:0] coef_a_q, coef_b_q;
  logic [31:0] coef_c_q, coef_d_q, b5_q;
  logic [1:0]  oss_q;
  logic        kind_q;
  logic [23:0] raw_q;
  logic [4:0]  step_q;
  // scratch registers
  logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q, prod_q;
  // divider
  logic [31:0] dnum_q, dden_q, drem_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;
  logic [31:0] res_q;
  logic        err_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(coef_a_q[47:32]);
  assign ac2 = sx16(coef_a_q[31:16]);
  assign ac3 = sx16(coef_a_q[15:0]);
  assign ac4 = {16'd0, coef_b_q[47:32]};
  assign ac5 = {16'd0, coef_b_q[31:16]};
  assign ac6 = {16'd0, coef_b_q[15:0]};
  assign b1  = sx16(coef_c_q[31:16]);
  assign b2  = sx16(coef_c_q[15:0]);
  assign mc  = sx16(coef_d_q[31:16]);
  assign md  = sx16(coef_d_q[15:0]);

  // shared multiplier operand select
  logic [31:0] ma, mb, up;
  assign up = {8'd0, raw_q} >> (5'd8 - {3'd0, oss_q});

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      5'd0:  begin ma = {16'd0, raw_q[15:0]} - ac6; mb = ac5; end // temp x1
      5'd1:  begin ma = mc; mb = 32'd2048; end                     // mc<<11
      5'd8:  begin ma = r0_q; mb = r0_q; end                       // b6*b6
      5'd9:  begin ma = r1_q; mb = b2; end                         // sq*b2
      5'd10: begin ma = ac2; mb = r0_q; end
      5'd11: begin ma = ac3; mb = r0_q; end
      5'd12: begin ma = b1; mb = r4_q; end                         // b1*sq
      5'd13: begin ma = ac4; mb = r4_q + B4Offset; end             // b4
      5'd14: begin ma = up - r2_q; mb = B7Scale >> oss_q; end      // b7
      5'd16: begin ma = asr(r0_q, 5'd8); mb = asr(r0_q, 5'd8); end // post
      5'd17: begin ma = prod_q; mb = PCoefA; end
      5'd18: begin ma = r0_q; mb = PCoefB; end
      default: ;
    endcase
  end

  logic [31:0] mres;
  assign mres = mul32(ma, mb);

  // one quotient bit per cycle (unsigned); remainder may use all 32 bits
  logic [32:0] dshift;
  logic [33:0] dtrial;
  assign dshift = {drem_q, dnum_q[31]};
  assign dtrial = {1'b0, dshift} - {2'b00, dden_q};

  logic [31:0] b3_calc, x3_calc, tden, tquot, b5_calc;

  always_comb begin
    b3_calc = asr((({ac1[29:0], 2'b00} + r1_q) << oss_q) + 32'd2, 5'd2);
    x3_calc = asr(r3_q + asr(mres, 5'd16) + 32'd2, 5'd2);
    tden    = r1_q + md;
    tquot   = dneg_q ? -dnum_q : dnum_q;
    b5_calc = r1_q + tquot;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready     = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = {err_q, kind_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (s_axis_tvalid) state_d = StMul;
      StMul: begin
        if (kind_q == ReqTemp && step_q == 5'd2) state_d = (tden == '0) ? StOut : StDiv;
        if (kind_q == ReqPres && step_q == 5'd15) state_d = (r4_q == '0) ? StOut : StDiv;
      end
      StDiv: if (dcnt_q == 6'd32) state_d = (kind_q == ReqTemp) ? StOut : StPost;
      StPost: if (step_q == 5'd19) state_d = StOut;
      StOut: if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      oss_q    <= 2'd1;
      b5_q     <= '0;
      step_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegCoefA: coef_a_q <= cfg_data;
          RegCoefB: coef_b_q <= cfg_data;
          RegCoefC: coef_c_q <= cfg_data[31:0];
          RegCoefD: coef_d_q <= cfg_data[31:0];
          RegOss:   oss_q    <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          step_q <= s_axis_tuser ? 5'd7 : 5'd0;
        end
        StMul: begin
          step_q <= step_q + 5'd1;
          if (state_d == StDiv) dcnt_q <= '0;
        end
        StDiv: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd32) begin
            step_q <= 5'd16;
            if (kind_q == ReqTemp) b5_q <= b5_calc;
          end
        end
        StPost: step_q <= step_q + 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mres;
    case (state_q)
      StIdle: begin
        kind_q <= s_axis_tuser;
        raw_q  <= s_axis_tdata;
        r0_q   <= b5_q - B6Offset;
        err_q  <= 1'b0;
        res_q  <= '0;
      end
      StMul: begin
        case (step_q)
          5'd0:  r1_q <= asr(mres, 5'd15);            // x1
          5'd1:  r2_q <= mres;                        // mc<<11
          5'd2: begin
            // signed divide r2 / (x1+md) on magnitudes, sign applied after
            dneg_q <= r2_q[31] ^ tden[31];
            dnum_q <= r2_q[31] ? -r2_q : r2_q;
            dden_q <= tden[31] ? -tden : tden;
            drem_q <= '0;
            if (tden == '0) begin
              err_q <= 1'b1;
              res_q <= '0;
            end
          end
          5'd8: begin                                 // sq, kept in r4 too
            r1_q <= asr(mres, 5'd12);
            r4_q <= asr(mres, 5'd12);
          end
          5'd9:  r3_q <= asr(mres, 5'd11);            // x1
          5'd10: r1_q <= r3_q + asr(mres, 5'd11);     // x3
          5'd11: r3_q <= asr(mres, 5'd13);
          5'd12: begin
            r2_q <= b3_calc;
            r4_q <= x3_calc;
          end
          5'd13: r4_q <= mres >> 15;                  // b4
          5'd14: begin
            dneg_q <= 1'b0;
            drem_q <= '0;
            dden_q <= r4_q;
            dnum_q <= mres[31] ? mres : (mres << 1);
            r3_q   <= {31'd0, mres[31]};             // shift after divide
          end
          5'd15: if (r4_q == '0) begin
            err_q <= 1'b1;
            res_q <= '0;
          end
          default: ;
        endcase
      end
      StDiv: begin
        if (dcnt_q != 6'd32) begin
          dnum_q <= {dnum_q[30:0], ~dtrial[33]};
          drem_q <= dtrial[33] ? dshift[31:0] : dtrial[31:0];
        end else if (kind_q == ReqTemp) begin
          res_q <= asr(b5_calc + 32'd8, 5'd4);
        end else begin
          r0_q <= r3_q[0] ? (dnum_q << 1) : dnum_q;
        end
      end
      StPost: begin
        case (step_q)
          5'd17: r1_q <= asr(mres, 5'd16);
          5'd18: r2_q <= asr(mres, 5'd16);
          5'd19: res_q <= r0_q + asr(r1_q + r2_q + PCoefC, 5'd4);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
